/* sv/ordered_array_insert_delete_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array block
// Short forms for the clocked, reset-qualified checks used in the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_DELETE_TOP_MACROS_SVH
`define ORDERED_ARRAY_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OAID_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OAID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/oaid_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array package
// Field widths, command and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package oaid_pkg;

  // Field widths of the item and result ports.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes.
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;
  localparam cmd_t CMD_UNUSED = 2'd3;

  // Status codes.
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_BADPOS = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_TAIL,
    S_READ,
    S_DONE
  } state_t;

endpackage

/* sv/ordered_array_insert_delete_top.sv */
// ----------------------------------------------------------------------------
// Ordered array with insert, delete and read at a position
// Keeps a dense array of signed 32-bit elements and reports status and count.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle and gives exactly one result.
// An insert or delete moves the entries between its position and the end of
// the array, one at a time, before its result is ready; a read or a rejected
// item moves none. If an earlier result is still waiting in the output
// register, the new result is held back and the block stays busy until the
// waiting one is taken. The block is ready for the next item from the edge
// that loads the result into the output register. The time an insert or
// delete takes is set by the element store's single read port and single
// write port: one entry moves per cycle, under one address counter.
module ordered_array_insert_delete_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [oaid_pkg::CMD_W-1:0]    in_command,
  input  logic [oaid_pkg::POS_W-1:0]    in_position,
  input  logic signed [oaid_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [oaid_pkg::STATUS_W-1:0] out_status,
  output logic signed [oaid_pkg::DATA_W-1:0] out_read_value,
  output logic [oaid_pkg::COUNT_W-1:0]  out_element_count
);
  import oaid_pkg::*;

  `include "ordered_array_insert_delete_top_macros.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  // Control registers.
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working registers of the current item.
  logic [CW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              ins_r, ins_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_value_r, res_value_nxt;

  // Output register.
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // Memory port signals.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Shared address unit and acceptance checks.
  logic [CW-1:0] addr_step;
  logic          more_moves;
  logic [XW-1:0] pos_x, cnt_x, cap_x;
  logic          accept;
  status_t       chk_status;

  oaid_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Shared address step: down for insert, up for delete.
  assign addr_step  = ins_r ? (addr_r - CW'(1)) : (addr_r + CW'(1));
  assign more_moves = ins_r ? (addr_r != pos_r) : (addr_step < count_r);

  // Status of the incoming item against the current count.
  assign pos_x = XW'(in_position);
  assign cnt_x = XW'(count_r);
  assign cap_x = XW'(CAPACITY);

  always_comb begin
    chk_status = ST_BADPOS;
    unique case (in_command)
      CMD_INSERT: begin
        if (cnt_x == cap_x) begin
          chk_status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          chk_status = ST_BADPOS;
        end else begin
          chk_status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (cnt_x == '0) begin
          chk_status = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          chk_status = ST_BADPOS;
        end else begin
          chk_status = ST_OK;
        end
      end
      CMD_READ: begin
        chk_status = (pos_x >= cnt_x) ? ST_BADPOS : ST_OK;
      end
      default: begin
        chk_status = ST_BADPOS;
      end
    endcase
  end

  // Sequencer: next state, working registers and memory port control.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    wr_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r;
    addr_nxt       = addr_r;
    wr_addr_nxt    = wr_addr_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    ins_nxt        = ins_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    mem_we         = wr_pend_r;
    mem_waddr      = wr_addr_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = addr_step[AW-1:0];

    // The output register empties when the result is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = AW'(in_position);
        if (accept) begin
          pos_nxt        = CW'(in_position);
          val_nxt        = $unsigned(in_value);
          ins_nxt        = (in_command == CMD_INSERT);
          res_status_nxt = chk_status;
          res_value_nxt  = '0;
          if (chk_status != ST_OK) begin
            state_nxt = S_DONE;
          end else if (in_command == CMD_INSERT) begin
            addr_nxt  = count_r;
            state_nxt = S_MOVE;
          end else if (in_command == CMD_DELETE) begin
            addr_nxt  = CW'(in_position);
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_MOVE: begin
        // One entry read per cycle; the write of the previous one trails it.
        if (more_moves) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = addr_r[AW-1:0];
          addr_nxt    = addr_step;
        end else if (ins_r) begin
          state_nxt = S_TAIL;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_TAIL: begin
        // Drop the new element into the gap.
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_READ: begin
        res_value_nxt = mem_rdata;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ins_r        <= ins_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = $signed(out_value_r);
  assign out_element_count = out_count_r;

  // Checks on the sequencer and the count.
  `OAID_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `OAID_ASSERT_IMPL(a_pend_in_move, wr_pend_r, state_r == S_MOVE, "write pending outside move")
  `OAID_ASSERT_IMPL(a_full_count, out_valid && (out_status == ST_FULL), out_element_count == COUNT_W'(CAPACITY), "full reported below capacity")
  `OAID_ASSERT_NEXT(a_unused_done, accept && (in_command == CMD_UNUSED), state_r == S_DONE, "unused command not rejected at once")

endmodule

/* sv/oaid_mem.sv */
// ----------------------------------------------------------------------------
// Element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaid_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [oaid_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [oaid_pkg::DATA_W-1:0] rdata
);
  import oaid_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, always enabled; the data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the ordered array block
// Drives insert, delete and read items through the valid/ready channels,
// keeps a shadow copy of the array and its count, and checks each result
// field by field in the order the items were accepted.
// ----------------------------------------------------------------------------
module tb_top;
  import oaid_pkg::*;

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        element_count;
  } array_outcome_t;

  // Shadow of the array: works out the outcome of each accepted item and
  // holds the outcomes still to be seen on the result channel.
  class ordered_array_tracker #(int unsigned SLOTS = 16);
    logic signed [DATA_W-1:0] shadow_array [SLOTS];
    int unsigned              shadow_count;
    array_outcome_t           outcome_fifo [$];
    int unsigned              mismatches;
    int unsigned              results_seen;
    int unsigned              status_hits [4];
    int unsigned              peak_count;

    function void note_request(input cmd_t cmd, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      array_outcome_t outcome;
      int unsigned    i;
      outcome.status     = ST_OK;
      outcome.read_value = '0;
      case (cmd)
        CMD_INSERT: begin
          // Full is judged before the position.
          if (shadow_count >= SLOTS) begin
            outcome.status = ST_FULL;
          end else if (pos > shadow_count) begin
            outcome.status = ST_BADPOS;
          end else begin
            for (i = shadow_count; i > pos; i--) begin
              shadow_array[i] = shadow_array[i-1];
            end
            shadow_array[pos] = val;
            shadow_count++;
          end
        end
        CMD_DELETE: begin
          // Empty is judged before the position.
          if (shadow_count == 0) begin
            outcome.status = ST_EMPTY;
          end else if (pos >= shadow_count) begin
            outcome.status = ST_BADPOS;
          end else begin
            for (i = pos; i + 1 < shadow_count; i++) begin
              shadow_array[i] = shadow_array[i+1];
            end
            shadow_count--;
          end
        end
        CMD_READ: begin
          if (pos >= shadow_count) begin
            outcome.status = ST_BADPOS;
          end else begin
            outcome.read_value = shadow_array[pos];
          end
        end
        default: begin
          outcome.status = ST_BADPOS;
        end
      endcase
      outcome.element_count = shadow_count[COUNT_W-1:0];
      if (shadow_count > peak_count) begin
        peak_count = shadow_count;
      end
      outcome_fifo.push_back(outcome);
    endfunction

    function void check_result(input status_t status,
                               input logic signed [DATA_W-1:0] read_value,
                               input logic [COUNT_W-1:0] element_count);
      array_outcome_t want;
      results_seen++;
      if (outcome_fifo.size() == 0) begin
        $error("result arrived with no item outstanding (status %0d)", status);
        mismatches++;
      end else begin
        want = outcome_fifo.pop_front();
        status_hits[want.status]++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, read_value);
          mismatches++;
        end
        if (element_count !== want.element_count) begin
          $error("element_count: expected %0d, got %0d", want.element_count,
                 element_count);
          mismatches++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return outcome_fifo.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           in_command = CMD_READ;
  logic [POS_W-1:0]           in_position = '0;
  logic signed [DATA_W-1:0]   in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic signed [DATA_W-1:0]   out_read_value;
  logic [COUNT_W-1:0]         out_element_count;

  ordered_array_tracker #(DEPTH) sb;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_cycles_left = 0;
  int unsigned items_sent = 0;

  ordered_array_insert_delete_top #(.CAPACITY(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each accepted result, then decide whether to stall.
  // A long hold-off, when requested, is counted down here.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_status, out_read_value, out_element_count);
    end
    if (hold_cycles_left != 0) begin
      hold_cycles_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one item, after a random gap, and return at the edge it is taken.
  task automatic send_item(input cmd_t cmd, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(cmd, pos, val);
    items_sent++;
  endtask

  // A position up to top, leaning towards both ends.
  function automatic logic [POS_W-1:0] position_within(input int unsigned top);
    case ($urandom_range(3))
      0:       return '0;
      1:       return top[POS_W-1:0];
      default: return POS_W'($urandom_range(top));
    endcase
  endfunction

  // Random items in waves that grow and shrink the array, so that it
  // regularly fills and empties, with a share of malformed items mixed in.
  task automatic send_random_items(input int unsigned n_items);
    cmd_t                     cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int unsigned              n;
    int unsigned              roll;
    int unsigned              cnt;
    bit                       growing;
    growing = $urandom_range(1);
    for (n = 0; n < n_items; n++) begin
      if ($urandom_range(39) == 0) begin
        growing = !growing;
      end
      cnt  = sb.shadow_count;
      roll = $urandom_range(99);
      if (roll < 8) begin
        cmd = cmd_t'($urandom_range(3));
        pos = POS_W'($urandom_range(31));
      end else begin
        roll = $urandom_range(99);
        if (roll < (growing ? 60 : 20)) begin
          cmd = CMD_INSERT;
        end else if (roll < 80) begin
          cmd = CMD_DELETE;
        end else begin
          cmd = CMD_READ;
        end
        if (cmd == CMD_INSERT) begin
          pos = position_within(cnt);
        end else begin
          pos = (cnt == 0) ? '0 : position_within(cnt - 1);
        end
      end
      case ($urandom_range(7))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7fff_ffff;
        2:       val = '0;
        3:       val = -32'sd1;
        default: val = $urandom();
      endcase
      send_item(cmd, pos, val);
    end
  endtask

  // Main sequence: reset, directed items, then random phases with
  // different amounts of idling on either side.
  initial begin
    int unsigned              k;
    int unsigned              drain_cycles;
    logic [POS_W-1:0]         fill_pos;
    logic signed [DATA_W-1:0] fill_val;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Failing items on an empty array; empty is reported before position.
    send_item(CMD_READ,   5'd0,  32'sd0);
    send_item(CMD_DELETE, 5'd31, 32'sd0);
    send_item(CMD_INSERT, 5'd1,  32'sd7);
    send_item(CMD_UNUSED, 5'd0,  32'sd0);

    // Fill to capacity, inserting at the start, the end and the middle.
    for (k = 0; k < DEPTH; k++) begin
      case (k % 3)
        0:       fill_pos = '0;
        1:       fill_pos = POS_W'(sb.shadow_count);
        default: fill_pos = POS_W'(sb.shadow_count / 2);
      endcase
      fill_val = (k == 0) ? 32'sh7fff_ffff : (k == 1) ? 32'sh8000_0000 : $urandom();
      send_item(CMD_INSERT, fill_pos, fill_val);
    end

    // Full is reported before the position is looked at.
    send_item(CMD_INSERT, 5'd31, 32'sd1);
    send_item(CMD_READ,   5'd0,  32'sd0);
    send_item(CMD_READ,   5'd15, 32'sd0);
    send_item(CMD_READ,   5'd16, 32'sd0);
    send_item(CMD_DELETE, 5'd16, 32'sd0);
    send_item(CMD_DELETE, 5'd15, 32'sd0);
    send_item(CMD_DELETE, 5'd0,  32'sd0);

    // Free-running phase with no idling on either side.
    send_random_items(300);

    // Sender leaves gaps.
    sender_idle_pct = 58;
    send_random_items(300);

    // Receiver stalls, opening with a long hold-off that backs up the input.
    sender_idle_pct    = 0;
    receiver_stall_pct = 58;
    hold_cycles_left   = 400;
    send_random_items(300);

    // Both sides idle now and then.
    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    send_random_items(320);
    in_valid <= 1'b0;

    // Let the outstanding results drain, then allow for stragglers.
    receiver_stall_pct = 0;
    drain_cycles = 0;
    while (sb.outstanding() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
      sb.mismatches++;
    end
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("Ran %0d items, %0d results: %0d ok, %0d full, %0d empty, %0d bad position.",
             items_sent, sb.results_seen, sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
             sb.status_hits[ST_EMPTY], sb.status_hits[ST_BADPOS]);
    $display("Array occupancy reached %0d of %0d entries; %0d mismatches.",
             sb.peak_count, DEPTH, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog in case the handshakes hang.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
